// ----- design/bmb_pkg.sv -----
package bmb_pkg;

  // Field widths of the request and response items.
  localparam int BAR_W      = 4;
  localparam int LVL_W      = 8;
  localparam int DISP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default number of bars held in the state memory.
  localparam int BAR_COUNT_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FALL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_MIN_RISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_MIN_FALL = 2'd3;

  // Configuration reset values.
  localparam logic [LVL_W-1:0]  PEAK_FALL_RST     = 8'd8;
  localparam logic [LVL_W-1:0]  TARGET_FALL_RST   = 8'd6;
  localparam logic [DISP_W-1:0] DISP_MIN_RISE_RST = 16'd48;
  localparam logic [DISP_W-1:0] DISP_MIN_FALL_RST = 16'd24;

  // Reciprocal constants for the truncating divisions by 5 and by 10.
  localparam logic [7:0]  RECIP5     = 8'd205;
  localparam int          RECIP5_SH  = 10;
  localparam logic [17:0] RECIP10    = 18'd209716;
  localparam int          RECIP10_SH = 21;

  // Per-bar state as stored in one memory word.
  typedef struct packed {
    logic [LVL_W-1:0]  tgt;
    logic [LVL_W-1:0]  cur;
    logic [LVL_W-1:0]  pk;
    logic [DISP_W-1:0] disp;
  } bmb_state_t;

  localparam int STATE_W = $bits(bmb_state_t);

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [LVL_W-1:0]  peak_fall_step;
    logic [LVL_W-1:0]  target_fall_step;
    logic [DISP_W-1:0] display_min_rise;
    logic [DISP_W-1:0] display_min_fall;
  } bmb_cfg_t;

endpackage

// ----- design/bmb_req_if.sv -----
interface bmb_req_if import bmb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [BAR_W-1:0] bar_index;
  logic [LVL_W-1:0] amplitude;

  modport source (output valid, req_type, bar_index, amplitude, input ready);
  modport sink   (input valid, req_type, bar_index, amplitude, output ready);
endinterface

// ----- design/bmb_rsp_if.sv -----
interface bmb_rsp_if import bmb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BAR_W-1:0] bar_out;
  logic [LVL_W-1:0] display_level;
  logic [LVL_W-1:0] peak_level;

  modport source (output valid, bar_out, display_level, peak_level, input ready);
  modport sink   (input valid, bar_out, display_level, peak_level, output ready);
endinterface

// ----- design/bmb_ram.sv -----
module bmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bmb_level.sv -----
module bmb_level import bmb_pkg::*; (
  input  bmb_state_t       st_i,
  input  logic             frame,
  input  logic [LVL_W-1:0] amp,
  input  bmb_cfg_t         cfg,
  output bmb_state_t       st_o
);

  logic [LVL_W-1:0] tgt_in;
  logic [LVL_W-1:0] pk_in;
  logic [LVL_W-1:0] gap_up;
  logic [LVL_W-1:0] gap_dn;
  logic [9:0]       up3;
  logic [8:0]       dn2;
  logic [16:0]      dn_prod;
  logic [6:0]       dn_q;
  logic [LVL_W-1:0] cur_new;
  logic [LVL_W:0]   pk_lim;
  logic [LVL_W-1:0] pk_new;
  logic [LVL_W-1:0] tgt_new;

  // A new frame loads the target and may raise the peak.
  always_comb begin
    tgt_in = frame ? amp : st_i.tgt;
    pk_in  = (frame && (amp > st_i.pk)) ? amp : st_i.pk;
  end

  // Level rises by 3/4 of the gap or falls by 2/5 of it, truncated.
  always_comb begin
    gap_up  = tgt_in - st_i.cur;
    gap_dn  = st_i.cur - tgt_in;
    up3     = ({2'b00, gap_up} << 1) + {2'b00, gap_up};
    dn2     = {gap_dn, 1'b0};
    dn_prod = dn2 * RECIP5;
    dn_q    = dn_prod[16:RECIP5_SH];
    if (st_i.cur < tgt_in) begin
      cur_new = st_i.cur + LVL_W'(up3 >> 2);
    end else begin
      cur_new = st_i.cur - {1'b0, dn_q};
    end
  end

  // Peak drops by its step but never below the new level.
  always_comb begin
    pk_lim = {1'b0, cur_new} + {1'b0, cfg.peak_fall_step};
    if (pk_in > cur_new) begin
      pk_new = ({1'b0, pk_in} < pk_lim) ? cur_new : pk_in - cfg.peak_fall_step;
    end else begin
      pk_new = pk_in;
    end
  end

  // Without a frame the target decays toward zero.
  always_comb begin
    if (!frame && (tgt_in != '0)) begin
      tgt_new = (tgt_in <= cfg.target_fall_step) ? '0 : tgt_in - cfg.target_fall_step;
    end else begin
      tgt_new = tgt_in;
    end
  end

  always_comb begin
    st_o.tgt  = tgt_new;
    st_o.cur  = cur_new;
    st_o.pk   = pk_new;
    st_o.disp = st_i.disp;
  end

endmodule

// ----- design/bmb_display.sv -----
module bmb_display import bmb_pkg::*; (
  input  logic [LVL_W-1:0]  cur,
  input  logic [DISP_W-1:0] disp,
  input  bmb_cfg_t          cfg,
  output logic [DISP_W-1:0] disp_o
);

  logic [DISP_W-1:0] goal;
  logic [DISP_W-1:0] rise_gap;
  logic [18:0]       rise_prod;
  logic [DISP_W-1:0] rise_st;
  logic [DISP_W-1:0] rise_st_m;
  logic [DISP_W:0]   rise_sum;
  logic [DISP_W-1:0] disp_up;
  logic [DISP_W-1:0] fall_gap;
  logic [17:0]       fall3;
  logic [35:0]       fall_prod;
  logic [DISP_W-1:0] fall_st;
  logic [DISP_W-1:0] fall_st_m;
  logic [DISP_W:0]   fall_lim;
  logic [DISP_W-1:0] disp_dn;

  assign goal = {cur, 8'h00};

  // Rise by 5/8 of the gap, at least the minimum step, clamped at the goal.
  always_comb begin
    rise_gap  = goal - disp;
    rise_prod = ({3'b000, rise_gap} << 2) + {3'b000, rise_gap};
    rise_st   = rise_prod[18:3];
    rise_st_m = (rise_st < cfg.display_min_rise) ? cfg.display_min_rise : rise_st;
    rise_sum  = {1'b0, disp} + {1'b0, rise_st_m};
    disp_up   = (rise_sum > {1'b0, goal}) ? goal : rise_sum[DISP_W-1:0];
  end

  // Fall by 3/10 of the gap through a reciprocal multiply, clamped at the goal.
  always_comb begin
    fall_gap  = disp - goal;
    fall3     = ({2'b00, fall_gap} << 1) + {2'b00, fall_gap};
    fall_prod = fall3 * RECIP10;
    fall_st   = {1'b0, fall_prod[35:RECIP10_SH]};
    fall_st_m = (fall_st < cfg.display_min_fall) ? cfg.display_min_fall : fall_st;
    fall_lim  = {1'b0, goal} + {1'b0, fall_st_m};
    disp_dn   = ({1'b0, disp} < fall_lim) ? goal : disp - fall_st_m;
  end

  always_comb begin
    if (goal > disp) begin
      disp_o = disp_up;
    end else if (goal < disp) begin
      disp_o = disp_dn;
    end else begin
      disp_o = disp;
    end
  end

endmodule

// ----- design/bar_meter_ballistics_unit.sv -----
// Channel   Direction  Payload                                   Transfer
// in_req    sink       req_type, bar_index, amplitude            valid && ready
// out_rsp   source     bar_out, display_level, peak_level        valid && ready
// cfg_*     sink       cfg_idx, cfg_wdata                        cfg_we
//
// One request per clock while the output is not stalled; each result passes stage 1, stage 2 and the output register.
// The rate is set by the state memory: one read and one write port, one bar per cycle.
// Back-to-back requests to the same bar are served by forwarding from the display stage
// and from the last write. Reset clears per-bar valid bits at once; no clearing pass.
// A stalled output backs up the two compute stages and then drops in_req.ready.
module bar_meter_ballistics_unit import bmb_pkg::*; #(
  parameter int BAR_COUNT = BAR_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmb_req_if.sink               in_req,
  bmb_rsp_if.source             out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BAR_AW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

  bmb_cfg_t cfg_r;

  logic              in_acc;
  logic              in_rng;
  logic [BAR_AW-1:0] rd_addr;
  logic [STATE_W-1:0] rd_data;
  logic              rd_vld_r;
  logic [BAR_COUNT-1:0] valid_r;

  logic              s1_v_r;
  logic              s1_frame_r;
  logic [BAR_W-1:0]  s1_bar_r;
  logic [LVL_W-1:0]  s1_amp_r;
  logic              s1_inr_r;
  logic [BAR_AW-1:0] s1_addr;
  logic              fwd_s2;
  logic              fwd_w;
  bmb_state_t        s1_base;
  bmb_state_t        s1_st_new;

  logic              s2_v_r;
  logic [BAR_W-1:0]  s2_bar_r;
  logic              s2_inr_r;
  bmb_state_t        s2_st_r;
  logic [DISP_W-1:0] s2_disp_new;
  bmb_state_t        s2_wr_st;

  logic              w_v_r;
  logic [BAR_AW-1:0] w_addr_r;
  bmb_state_t        w_st_r;
  logic              wr_en;
  logic [BAR_AW-1:0] wr_addr;

  logic              out_v_r;
  logic [BAR_W-1:0]  out_bar_r;
  logic [LVL_W-1:0]  out_disp_r;
  logic [LVL_W-1:0]  out_peak_r;

  logic              out_en;
  logic              s2_load;
  logic              s1_load;
  logic              s2_go;
  logic              s1_go;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_fall_step   <= PEAK_FALL_RST;
      cfg_r.target_fall_step <= TARGET_FALL_RST;
      cfg_r.display_min_rise <= DISP_MIN_RISE_RST;
      cfg_r.display_min_fall <= DISP_MIN_FALL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PEAK_FALL:     cfg_r.peak_fall_step   <= cfg_wdata[LVL_W-1:0];
        CFG_TARGET_FALL:   cfg_r.target_fall_step <= cfg_wdata[LVL_W-1:0];
        CFG_DISP_MIN_RISE: cfg_r.display_min_rise <= cfg_wdata[DISP_W-1:0];
        CFG_DISP_MIN_FALL: cfg_r.display_min_fall <= cfg_wdata[DISP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake: each stage loads when it is empty or drains forward.
  always_comb begin
    out_en       = !out_v_r || out_rsp.ready;
    s2_load      = !s2_v_r || out_en;
    s1_load      = !s1_v_r || s2_load;
    s2_go        = s2_v_r && out_en;
    s1_go        = s1_v_r && s2_load;
    in_req.ready = s1_load;
    in_acc       = in_req.valid && s1_load;
  end

  // Request decode and memory read issue.
  assign in_rng  = (32'(in_req.bar_index) < 32'(BAR_COUNT));
  assign rd_addr = BAR_AW'(in_req.bar_index);

  bmb_ram #(
    .WIDTH (STATE_W),
    .DEPTH (BAR_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (s2_wr_st),
    .re    (in_acc && in_rng),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Stage 1 request registers and the valid bit of the entry being read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_frame_r <= in_req.req_type;
      s1_bar_r   <= in_req.bar_index;
      s1_amp_r   <= in_req.amplitude;
      s1_inr_r   <= in_rng;
      rd_vld_r   <= in_rng && valid_r[rd_addr];
    end
  end

  // Pick the newest copy of the bar's state: display stage, last write, then memory.
  always_comb begin
    s1_addr = BAR_AW'(s1_bar_r);
    fwd_s2  = s2_v_r && s2_inr_r && (s2_bar_r == s1_bar_r);
    fwd_w   = w_v_r && (w_addr_r == s1_addr);
    if (fwd_s2) begin
      s1_base = s2_wr_st;
    end else if (fwd_w) begin
      s1_base = w_st_r;
    end else if (rd_vld_r) begin
      s1_base = rd_data;
    end else begin
      s1_base = '0;
    end
  end

  bmb_level u_level (
    .st_i  (s1_base),
    .frame (s1_frame_r),
    .amp   (s1_amp_r),
    .cfg   (cfg_r),
    .st_o  (s1_st_new)
  );

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_bar_r <= s1_bar_r;
      s2_inr_r <= s1_inr_r;
      s2_st_r  <= s1_st_new;
    end
  end

  bmb_display u_display (
    .cur    (s2_st_r.cur),
    .disp   (s2_st_r.disp),
    .cfg    (cfg_r),
    .disp_o (s2_disp_new)
  );

  // Write-back of the updated state.
  always_comb begin
    s2_wr_st      = s2_st_r;
    s2_wr_st.disp = s2_disp_new;
    wr_en         = s2_go && s2_inr_r;
    wr_addr       = BAR_AW'(s2_bar_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      w_v_r   <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      w_v_r            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_addr_r <= wr_addr;
      w_st_r   <= s2_wr_st;
    end
  end

  // Output register; a bar outside the array reports zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_bar_r  <= s2_bar_r;
      out_disp_r <= s2_inr_r ? s2_disp_new[DISP_W-1:LVL_W] : '0;
      out_peak_r <= s2_inr_r ? s2_st_r.pk : '0;
    end
  end

  assign out_rsp.valid         = out_v_r;
  assign out_rsp.bar_out       = out_bar_r;
  assign out_rsp.display_level = out_disp_r;
  assign out_rsp.peak_level    = out_peak_r;

endmodule

// ----- design/bmb_checker.sv -----
module bmb_props import bmb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [BAR_W-1:0] out_bar,
  input logic [LVL_W-1:0] out_disp,
  input logic [LVL_W-1:0] out_peak
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests taken but not yet answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  // A stalled response keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bar) && $stable(out_disp)
      && $stable(out_peak))
    else $error("response changed while stalled");

  // No response without a pending request.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("response without a pending request");

  // At most three requests are in the pipeline at once.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more requests in flight than pipeline stages");

  // An empty pipeline always takes a request.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 3'd0 |-> in_ready)
    else $error("empty pipeline refused a request");

endmodule

bind bar_meter_ballistics_unit bmb_props u_bmb_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_bar   (out_rsp.bar_out),
  .out_disp  (out_rsp.display_level),
  .out_peak  (out_rsp.peak_level)
);
